/* hw/rtl/tscw_pkg.sv */
package tscw_pkg;

    // Geometry defaults of the character display.
    localparam int DEF_COLUMNS     = 20;
    localparam int DEF_ROWS        = 4;
    // Depth of the command queue between front and back.
    localparam int DEF_QUEUE_DEPTH = 4;

    // Field widths of one result item on the output stream.
    localparam int ROW_W  = 2;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;

    // Most results one character can cause.
    localparam int MAX_RES = 3;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

    // Accented codes and the glyph slots they map to.
    localparam logic [CHAR_W-1:0] ACC_U_UML  = 8'd220;
    localparam logic [CHAR_W-1:0] ACC_O_UML  = 8'd214;
    localparam logic [CHAR_W-1:0] ACC_A_UML  = 8'd196;
    localparam logic [CHAR_W-1:0] ACC_AE     = 8'd198;
    localparam logic [CHAR_W-1:0] ACC_O_STR  = 8'd216;
    localparam logic [CHAR_W-1:0] ACC_A_RING = 8'd197;
    localparam logic [CHAR_W-1:0] ACC_N_TIL  = 8'd209;

    localparam logic [CHAR_W-1:0] GLYPH_U_UML  = 8'd0;
    localparam logic [CHAR_W-1:0] GLYPH_O_UML  = 8'd1;
    localparam logic [CHAR_W-1:0] GLYPH_A_UML  = 8'd2;
    localparam logic [CHAR_W-1:0] GLYPH_AE     = 8'd3;
    localparam logic [CHAR_W-1:0] GLYPH_O_STR  = 8'd4;
    localparam logic [CHAR_W-1:0] GLYPH_A_RING = 8'd6;
    localparam logic [CHAR_W-1:0] GLYPH_N_TIL  = 8'd7;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SCROLL = 1'b1
    } cmd_kind_t;

    // One display command as it leaves the block.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] chr;
    } result_t;

    // All commands caused by one character, in emission order.
    typedef struct packed {
        logic [1:0]              count;
        result_t [MAX_RES-1:0]   res;
    } job_t;

    // Replace the accented codes by their custom glyph slots.
    function automatic logic [CHAR_W-1:0] remap(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        case (c)
            ACC_U_UML:  r = GLYPH_U_UML;
            ACC_O_UML:  r = GLYPH_O_UML;
            ACC_A_UML:  r = GLYPH_A_UML;
            ACC_AE:     r = GLYPH_AE;
            ACC_O_STR:  r = GLYPH_O_STR;
            ACC_A_RING: r = GLYPH_A_RING;
            ACC_N_TIL:  r = GLYPH_N_TIL;
            default:    r = c;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/tscw_front.sv */
module tscw_front
    import tscw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              remap_enable,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              q_full,
    output logic              push,
    output job_t              push_job
);

    localparam int CW = $clog2(COLUMNS + 1);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          pend_reg, pend_next;
    logic          accept;
    logic          is_space;
    logic [CHAR_W-1:0] c;
    logic [1:0]    n;

    // Fit a cursor position into the output field widths.
    function automatic logic [ROW_W-1:0] fit_row(input logic [RW-1:0] r);
        logic [RW+ROW_W-1:0] ext;
        ext = {{ROW_W{1'b0}}, r};
        return ext[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] fit_col(input logic [CW-1:0] k);
        logic [CW+COL_W-1:0] ext;
        ext = {{COL_W{1'b0}}, k};
        return ext[COL_W-1:0];
    endfunction

    function automatic result_t wr_cmd(input logic [RW-1:0] r, input logic [CW-1:0] k,
                                       input logic [CHAR_W-1:0] ch);
        result_t x;
        x.kind = CMD_WRITE;
        x.row  = fit_row(r);
        x.col  = fit_col(k);
        x.chr  = ch;
        return x;
    endfunction

    function automatic result_t scroll_cmd();
        result_t x;
        x      = '0;
        x.kind = CMD_SCROLL;
        return x;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the character and work out its commands and the new cursor.
    always_comb
    begin
        c         = remap_enable ? remap(char_in) : char_in;
        is_space  = (c == SPACE_CODE);
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        push_job  = '0;
        n         = 2'd0;
        if (is_space)
        begin
            pend_next = 1'b1;
        end
        else
        begin
            if (pend_reg)
            begin
                if (col_next > COL_LAST)
                begin
                    col_next = '0;
                    if (row_next == ROW_LAST)
                    begin
                        push_job.res[n] = scroll_cmd();
                        n = n + 2'd1;
                    end
                    else
                    begin
                        row_next = row_next + RW'(1);
                    end
                end
                // A held space that would land in the first column is dropped.
                if (col_next != '0)
                begin
                    push_job.res[n] = wr_cmd(row_next, col_next, SPACE_CODE);
                    n = n + 2'd1;
                    col_next = col_next + CW'(1);
                end
                pend_next = 1'b0;
            end
            if (col_next > COL_LAST)
            begin
                col_next = '0;
                if (row_next == ROW_LAST)
                begin
                    push_job.res[n] = scroll_cmd();
                    n = n + 2'd1;
                end
                else
                begin
                    row_next = row_next + RW'(1);
                end
            end
            push_job.res[n] = wr_cmd(row_next, col_next, c);
            n = n + 2'd1;
            col_next = col_next + CW'(1);
        end
        push_job.count = n;
        push = accept && !is_space;
    end

    // Cursor state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= CW'(COLUMNS)) && (row_reg <= ROW_LAST))
        else $error("cursor left the display");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.count != 2'd0) && (push_job.res[push_job.count - 2'd1].kind == CMD_WRITE))
        else $error("job does not end in a character write");

endmodule

/* hw/rtl/tscw_queue.sv */
module tscw_queue
    import tscw_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t        mem_reg [DEPTH];
    logic [AW:0] wptr_reg, rptr_reg;

    // Pointers carry one extra wrap bit to tell full from empty.
    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[AW] != rptr_reg[AW]) &&
                   (wptr_reg[AW-1:0] == rptr_reg[AW-1:0]);
    assign head  = mem_reg[rptr_reg[AW-1:0]];

    function automatic logic [AW:0] bump(input logic [AW:0] p);
        logic [AW:0] q;
        if (p[AW-1:0] == AW'(DEPTH - 1))
        begin
            q = {~p[AW], {AW{1'b0}}};
        end
        else
        begin
            q = p + (AW+1)'(1);
        end
        return q;
    endfunction

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg[AW-1:0]] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop && !empty)
            begin
                rptr_reg <= bump(rptr_reg);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push |-> !full) and (pop |-> !empty))
        else $error("queue pushed while full or popped while empty");

endmodule

/* hw/rtl/tscw_back.sv */
module tscw_back
    import tscw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              head,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res,
    output logic              out_last
);

    logic       vld_reg;
    result_t    res_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_end;

    // Step through the head job into the output register, one command per cycle while the output is accepted.
    always_comb
    begin
        load     = !q_empty && (!vld_reg || out_ready);
        at_end   = (idx_reg == (head.count - 2'd1));
        pop      = load && at_end;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = at_end ? 2'd0 : (idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.res[idx_reg];
            last_reg <= at_end;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < head.count))
        else $error("command index beyond the head job");

    a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("command index not cleared after the job finished");

endmodule

/* hw/rtl/text_scroll_cursor_wrap.sv */
// Channel        | Dir | Payload (low bit first)                        | Transfer
// s_axis         | in  | tdata: char_in[7:0]                            | tvalid & tready
// m_axis         | out | tdata: cell_row, cell_col, cell_char, pad;     | tvalid & tready
//                |     | tuser: cmd_kind; tlast: last                   |
// cfg            | in  | cfg_wdata: remap_enable                        | cfg_we
//
// The front accepts one character per cycle while the command queue has room;
// a space pushes nothing itself but is held and written ahead of the next character unless it would land in column 0.
// The back emits one command per cycle from its output register while m_axis is ready,
// and a character yields 1 to 3 commands; that output register sets the sustained rate.
// Reset clears the cursor, the held space, the queue and remap_enable.
// Either side may stall without losing commands; the queue absorbs the slack.
module text_scroll_cursor_wrap
    import tscw_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int ROWS        = DEF_ROWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cell_row[1:0], cell_col[6:2], cell_char[14:7], 0[15]
    output logic        m_axis_tuser,   // cmd_kind[0]
    output logic        m_axis_tlast
);

    logic    remap_reg;
    logic    q_full, q_empty;
    logic    push, pop;
    job_t    push_job, head;
    result_t out_res;

    // Remap control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            remap_reg <= cfg_wdata;
        end
    end

    tscw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .remap_enable (remap_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .char_in      (s_axis_tdata),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    tscw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    tscw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    // Pack the command onto the output stream.
    assign m_axis_tdata = {1'b0, out_res.chr, out_res.col, out_res.row};
    assign m_axis_tuser = out_res.kind;

endmodule
